@@ rtl/core/efpm_pkg.sv @@
// shared types and constants for the earliest-finish pe mapper
package efpm_pkg;

   localparam int NUM_PE_DEF    = 8;
   localparam int NUM_TYPES_DEF = 4;
   localparam int TIME_BITS_DEF = 48;

   localparam int TIME_W     = 48;
   localparam int EXEC_W     = 32;
   localparam int EXEC_SLOTS = 4;
   localparam int JOB_W      = 16;
   localparam int MASK_W     = 8;
   localparam int PE_W       = 3;
   localparam int TYPE_W     = 2;
   localparam int MAP_W      = 16;
   localparam int CHARGE_W   = 32;
   localparam int TAG_W      = 4;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_W-1:0] MAP_COST_RST = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PE_TYPE_MAP  = 1'b0,
      CSR_MAPPING_COST = 1'b1
   } csr_idx_type;

   typedef enum logic {
      CMD_INIT     = 1'b0,
      CMD_SCHEDULE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef logic [EXEC_SLOTS-1:0][EXEC_W-1:0] exec_set_type;

   typedef struct packed {
      logic              cmd;
      logic [TIME_W-1:0] time_value;
      logic [JOB_W-1:0]  job_count;
      logic [MASK_W-1:0] allowed_mask;
      logic [EXEC_W-1:0] exec_time_type0;
      logic [EXEC_W-1:0] exec_time_type1;
      logic [EXEC_W-1:0] exec_time_type2;
      logic [EXEC_W-1:0] exec_time_type3;
   } req_payload_type;

   typedef struct packed {
      logic [PE_W-1:0]   pe_index;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
      logic              found;
   } rsp_payload_type;

   // read tag registered alongside a memory read, so it arrives with the read data
   typedef struct packed {
      logic             vld;
      logic [TAG_W-1:0] idx;
   } tag_type;

   typedef struct packed {
      logic            found;
      logic [PE_W-1:0] pe_index;
   } best_type;

endpackage

@@ rtl/core/efpm_stream_if.sv @@
// valid/ready stream interface carrying one payload per beat
interface efpm_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

@@ rtl/core/efpm_ready_mem.sv @@
// ready-time memory, one write and one registered read per cycle
module efpm_ready_mem #(
   parameter int NUM_PE    = efpm_pkg::NUM_PE_DEF,
   parameter int TIME_BITS = efpm_pkg::TIME_BITS_DEF,
   localparam int AW       = (NUM_PE > 1) ? $clog2(NUM_PE) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [AW-1:0]        rd_addr,
   output logic [TIME_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [TIME_BITS-1:0] wr_data
);

   logic [TIME_BITS-1:0] mem [NUM_PE];
   logic [TIME_BITS-1:0] data_ff;
   logic [NUM_PE-1:0]    vld_ff;
   logic                 hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      data_ff <= mem[rd_addr];
   end

   // entries never written since reset read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         hit_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

@@ rtl/core/efpm_eval.sv @@
// per-element start, wait and end pipeline with running earliest-finish pick
module efpm_eval #(
   parameter int NUM_TYPES = efpm_pkg::NUM_TYPES_DEF,
   parameter int TIME_BITS = efpm_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  efpm_pkg::tag_type             tag,
   input  logic [TIME_BITS-1:0]          rd_data,
   input  logic [TIME_BITS-1:0]          t_value,
   input  logic [efpm_pkg::MASK_W-1:0]   mask,
   input  logic [efpm_pkg::MAP_W-1:0]    type_map,
   input  efpm_pkg::exec_set_type        exec_set,
   output logic                          busy,
   output efpm_pkg::best_type            best,
   output logic [TIME_BITS-1:0]          best_start,
   output logic [TIME_BITS-1:0]          best_end
);

   localparam int SUM_W = ((TIME_BITS > efpm_pkg::EXEC_W) ? TIME_BITS : efpm_pkg::EXEC_W) + 1;

   logic [efpm_pkg::PE_W-1:0]   idx0;
   logic [efpm_pkg::TYPE_W-1:0] typ0;
   logic                        elig0;
   logic [TIME_BITS:0]          diff0;
   logic                        late0;
   logic [TIME_BITS-1:0]        start0;
   logic [TIME_BITS-1:0]        wait0;

   logic                        s1_vld_ff;
   logic                        s1_elig_ff;
   logic [efpm_pkg::PE_W-1:0]   s1_idx_ff;
   logic [TIME_BITS-1:0]        s1_start_ff;
   logic [TIME_BITS-1:0]        s1_wait_ff;
   logic [efpm_pkg::EXEC_W-1:0] s1_exec_ff;

   logic [SUM_W-1:0]            sum1;
   logic [TIME_BITS-1:0]        end1;

   logic                        s2_vld_ff;
   logic                        s2_elig_ff;
   logic [efpm_pkg::PE_W-1:0]   s2_idx_ff;
   logic [TIME_BITS-1:0]        s2_start_ff;
   logic [TIME_BITS-1:0]        s2_wait_ff;
   logic [TIME_BITS-1:0]        s2_end_ff;

   logic                        found_ff;
   logic [efpm_pkg::PE_W-1:0]   best_idx_ff;
   logic [TIME_BITS-1:0]        best_start_ff;
   logic [TIME_BITS-1:0]        best_end_ff;
   logic [TIME_BITS-1:0]        best_wait_ff;
   logic                        take;

   // stage 0: eligibility and start time from the read ready time
   always_comb begin
      idx0   = efpm_pkg::PE_W'(tag.idx);
      typ0   = type_map[{idx0, 1'b0} +: efpm_pkg::TYPE_W];
      elig0  = mask[idx0] && ({1'b0, typ0} < 3'(NUM_TYPES));
      diff0  = {1'b0, t_value} - {1'b0, rd_data};
      late0  = diff0[TIME_BITS];
      start0 = late0 ? rd_data : t_value;
      wait0  = late0 ? '0 : diff0[TIME_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      s1_elig_ff  <= elig0;
      s1_idx_ff   <= idx0;
      s1_start_ff <= start0;
      s1_wait_ff  <= wait0;
      s1_exec_ff  <= exec_set[typ0];
      s2_elig_ff  <= s1_elig_ff;
      s2_idx_ff   <= s1_idx_ff;
      s2_start_ff <= s1_start_ff;
      s2_wait_ff  <= s1_wait_ff;
      s2_end_ff   <= end1;
   end

   // stage 1: saturating end time
   always_comb begin
      sum1 = SUM_W'(s1_start_ff) + SUM_W'(s1_exec_ff);
      end1 = (|sum1[SUM_W-1:TIME_BITS]) ? '1 : sum1[TIME_BITS-1:0];
   end

   // stage 2: strict compares keep the lower index on a full tie
   assign take = s2_vld_ff && s2_elig_ff &&
                 (!found_ff || (s2_end_ff < best_end_ff) ||
                  ((s2_end_ff == best_end_ff) && (s2_wait_ff < best_wait_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         s1_vld_ff <= tag.vld;
         s2_vld_ff <= s1_vld_ff;
         if (clear) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff   <= s2_idx_ff;
         best_start_ff <= s2_start_ff;
         best_end_ff   <= s2_end_ff;
         best_wait_ff  <= s2_wait_ff;
      end
   end

   assign busy          = s1_vld_ff | s2_vld_ff;
   assign best.found    = found_ff;
   assign best.pe_index = best_idx_ff;
   assign best_start    = best_start_ff;
   assign best_end      = best_end_ff;

endmodule

@@ rtl/core/earliest_finish_pe_mapper.sv @@
// Earliest-finish pe mapper. Ready times of the elements sit in a one-port-read memory that
// is swept one entry per cycle. An init beat reads every entry and raises it to the init
// time; element 0 gets the init time plus mapping_cost * job_count. A schedule beat reads
// the first min(NUM_PE, 8) entries in turn through a three-stage start/end/compare pipeline,
// then writes back the winner's ready time and loads the result into the output register.
// A schedule beat whose result finds the output register still full waits in that last step.
// No result is produced for init beats. Times saturate at all ones of TIME_BITS. A new beat
// is accepted only when the previous one is finished and the block is back in idle.
module earliest_finish_pe_mapper #(
   parameter int NUM_PE    = efpm_pkg::NUM_PE_DEF,
   parameter int NUM_TYPES = efpm_pkg::NUM_TYPES_DEF,
   parameter int TIME_BITS = efpm_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   efpm_stream_if.sink                    req_chan,
   efpm_stream_if.source                  rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [efpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [efpm_pkg::CSR_W-1:0]     csr_wr_data
);

   localparam int AW       = (NUM_PE > 1) ? $clog2(NUM_PE) : 1;
   localparam int CNT_W    = $clog2(NUM_PE + 1);
   localparam int SCAN_PE  = (NUM_PE < efpm_pkg::MASK_W) ? NUM_PE : efpm_pkg::MASK_W;
   localparam int SUM_W    = ((TIME_BITS > efpm_pkg::CHARGE_W) ? TIME_BITS : efpm_pkg::CHARGE_W) + 1;
   localparam logic [CNT_W-1:0] LAST_ALL  = CNT_W'(NUM_PE - 1);
   localparam logic [CNT_W-1:0] LAST_SCAN = CNT_W'(SCAN_PE - 1);

   efpm_pkg::state_type           state_ff, state_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   efpm_pkg::tag_type             tag_ff, tag_in, scan_tag;

   logic                          cmd_ff;
   logic [TIME_BITS-1:0]          t_ff;
   logic [efpm_pkg::MASK_W-1:0]   mask_ff;
   efpm_pkg::exec_set_type        exec_ff;
   logic [efpm_pkg::CHARGE_W-1:0] charge_ff;

   logic [efpm_pkg::MAP_W-1:0]    type_map_ff;
   logic [efpm_pkg::CSR_W-1:0]    map_cost_ff;

   logic                          rsp_vld_ff, rsp_vld_in;
   efpm_pkg::rsp_payload_type     rsp_ff, rsp_in;

   logic                          accept;
   logic                          is_init;
   logic                          slot_free;
   logic                          issue;
   logic                          commit;
   logic                          init_wr;

   logic [TIME_BITS-1:0]          rd_data;
   logic                          mem_wr_en;
   logic [AW-1:0]                 mem_wr_addr;
   logic [TIME_BITS-1:0]          mem_wr_data;
   logic [SUM_W-1:0]              init_sum;
   logic [TIME_BITS-1:0]          init_val;

   logic                          eval_busy;
   efpm_pkg::best_type            best;
   logic [TIME_BITS-1:0]          best_start;
   logic [TIME_BITS-1:0]          best_end;

   assign accept    = req_chan.valid && req_chan.ready;
   assign is_init   = (cmd_ff == efpm_pkg::CMD_INIT);
   assign slot_free = !rsp_vld_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         efpm_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_chan.payload.cmd == efpm_pkg::CMD_INIT) ?
                          efpm_pkg::ST_INIT : efpm_pkg::ST_SCAN;
            end
         end
         efpm_pkg::ST_INIT: begin
            if (cnt_ff == LAST_ALL) begin
               state_in = efpm_pkg::ST_DRAIN;
            end
         end
         efpm_pkg::ST_SCAN: begin
            if (cnt_ff == LAST_SCAN) begin
               state_in = efpm_pkg::ST_DRAIN;
            end
         end
         efpm_pkg::ST_DRAIN: begin
            if (!tag_ff.vld && !eval_busy) begin
               state_in = is_init ? efpm_pkg::ST_IDLE : efpm_pkg::ST_COMMIT;
            end
         end
         efpm_pkg::ST_COMMIT: begin
            if (slot_free) begin
               state_in = efpm_pkg::ST_IDLE;
            end
         end
         default: state_in = efpm_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = (state_ff == efpm_pkg::ST_IDLE);
      issue          = (state_ff == efpm_pkg::ST_INIT) || (state_ff == efpm_pkg::ST_SCAN);
      commit         = (state_ff == efpm_pkg::ST_COMMIT) && slot_free;
      cnt_in         = issue ? cnt_ff + 1'b1 : '0;
      tag_in.vld     = issue;
      tag_in.idx     = efpm_pkg::TAG_W'(cnt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= efpm_pkg::ST_IDLE;
         cnt_ff     <= '0;
         tag_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         tag_ff     <= tag_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         type_map_ff <= '0;
         map_cost_ff <= efpm_pkg::MAP_COST_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            efpm_pkg::CSR_PE_TYPE_MAP:  type_map_ff <= csr_wr_data;
            efpm_pkg::CSR_MAPPING_COST: map_cost_ff <= csr_wr_data;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff     <= req_chan.payload.cmd;
         t_ff       <= TIME_BITS'(req_chan.payload.time_value);
         mask_ff    <= req_chan.payload.allowed_mask;
         exec_ff    <= {req_chan.payload.exec_time_type3, req_chan.payload.exec_time_type2,
                        req_chan.payload.exec_time_type1, req_chan.payload.exec_time_type0};
         charge_ff  <= map_cost_ff * req_chan.payload.job_count;
      end
   end

   // init write-back: element 0 gets the mapping charge, the rest are raised to the init time
   always_comb begin
      init_sum = SUM_W'(t_ff) + SUM_W'(charge_ff);
      if (tag_ff.idx == '0) begin
         init_val = (|init_sum[SUM_W-1:TIME_BITS]) ? '1 : init_sum[TIME_BITS-1:0];
      end else begin
         init_val = (rd_data < t_ff) ? t_ff : rd_data;
      end
   end

   assign init_wr     = tag_ff.vld && is_init;
   assign mem_wr_en   = init_wr || (commit && best.found);
   assign mem_wr_addr = init_wr ? AW'(tag_ff.idx) : AW'(best.pe_index);
   assign mem_wr_data = init_wr ? init_val : best_end;

   assign scan_tag.vld = tag_ff.vld && !is_init;
   assign scan_tag.idx = tag_ff.idx;

   efpm_ready_mem #(
      .NUM_PE    (NUM_PE),
      .TIME_BITS (TIME_BITS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   efpm_eval #(
      .NUM_TYPES (NUM_TYPES),
      .TIME_BITS (TIME_BITS)
   ) u_eval (
      .clock      (clock),
      .reset      (reset),
      .clear      (accept),
      .tag        (scan_tag),
      .rd_data    (rd_data),
      .t_value    (t_ff),
      .mask       (mask_ff),
      .type_map   (type_map_ff),
      .exec_set   (exec_ff),
      .busy       (eval_busy),
      .best       (best),
      .best_start (best_start),
      .best_end   (best_end)
   );

   // output register: one beat per schedule item
   always_comb begin
      rsp_vld_in        = commit || (rsp_vld_ff && !rsp_chan.ready);
      rsp_in.found      = best.found;
      rsp_in.pe_index   = best.found ? best.pe_index : '0;
      rsp_in.start_time = best.found ? efpm_pkg::TIME_W'(best_start) : '0;
      rsp_in.end_time   = best.found ? efpm_pkg::TIME_W'(best_end) : '0;
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

@@ tb/tb_earliest_finish_pe_mapper.sv @@
`timescale 1ns / 1ps
// testbench for the earliest-finish pe mapper: directed and random beats checked by a predictor
module tb_earliest_finish_pe_mapper;
   import efpm_pkg::*;

   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 32;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_BEATS  = 300;
   localparam logic [TIME_W-1:0] T_MAX = '1;

   // predicts placements from the ready times and checks what the block reports
   class finish_time_board;
      logic [TIME_W-1:0] ready_time [NUM_PE_DEF];
      logic [MAP_W-1:0]  type_map;
      logic [CSR_W-1:0]  map_cost;
      rsp_payload_type   placements_q [$];
      int unsigned       errors;

      function new();
         foreach (ready_time[p]) ready_time[p] = '0;
         type_map = '0;
         map_cost = MAP_COST_RST;
         errors   = 0;
      endfunction

      function logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
         logic [TIME_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[TIME_W] ? T_MAX : s[TIME_W-1:0];
      endfunction

      function void write_reg(csr_idx_type idx, logic [CSR_W-1:0] v);
         case (idx)
            CSR_PE_TYPE_MAP:  type_map = v;
            CSR_MAPPING_COST: map_cost = v;
            default: ;
         endcase
      endfunction

      function void take_request(req_payload_type r);
         logic [CHARGE_W-1:0] charge;
         logic [EXEC_W-1:0]   exec;
         logic [TYPE_W-1:0]   kind;
         logic [TIME_W-1:0]   start, wait_t, fin, best_wait;
         rsp_payload_type     best;
         if (r.cmd == CMD_INIT) begin
            charge = map_cost * r.job_count;
            foreach (ready_time[p])
               if (ready_time[p] < r.time_value) ready_time[p] = r.time_value;
            ready_time[0] = sat_sum(r.time_value, TIME_W'(charge));
            return;
         end
         best      = '0;
         best_wait = '0;
         for (int p = 0; p < NUM_PE_DEF; p++) begin
            if (!r.allowed_mask[p]) continue;
            kind = type_map[TYPE_W*p +: TYPE_W];
            case (kind)
               2'd0:    exec = r.exec_time_type0;
               2'd1:    exec = r.exec_time_type1;
               2'd2:    exec = r.exec_time_type2;
               default: exec = r.exec_time_type3;
            endcase
            start  = (ready_time[p] > r.time_value) ? ready_time[p] : r.time_value;
            wait_t = start - ready_time[p];
            fin    = sat_sum(start, TIME_W'(exec));
            // earliest end, then shortest wait, then lowest index
            if (!best.found || fin < best.end_time ||
                (fin == best.end_time && wait_t < best_wait)) begin
               best.found      = 1'b1;
               best.pe_index   = p[PE_W-1:0];
               best.start_time = start;
               best.end_time   = fin;
               best_wait       = wait_t;
            end
         end
         if (best.found) ready_time[best.pe_index] = best.end_time;
         placements_q.push_back(best);
      endfunction

      task report(string msg);
         $display("placement mismatch: %s", msg);
         errors++;
      endtask

      task check_placement(rsp_payload_type got);
         rsp_payload_type want;
         if (placements_q.size() == 0) begin
            report($sformatf("result with nothing pending: pe %0d found %0b",
                             got.pe_index, got.found));
            return;
         end
         want = placements_q.pop_front();
         if (got.found !== want.found)
            report($sformatf("found %0b, want %0b", got.found, want.found));
         if (got.pe_index !== want.pe_index)
            report($sformatf("pe_index %0d, want %0d", got.pe_index, want.pe_index));
         if (got.start_time !== want.start_time)
            report($sformatf("start_time %h, want %h", got.start_time, want.start_time));
         if (got.end_time !== want.end_time)
            report($sformatf("end_time %h, want %h", got.end_time, want.end_time));
      endtask

      task drain_check();
         rsp_payload_type want;
         while (placements_q.size() != 0) begin
            want = placements_q.pop_front();
            report($sformatf("result never came: pe %0d end %h", want.pe_index, want.end_time));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wr_data = '0;
   logic                 hold_start = 1'b0;
   int                   snd_idle_pct = 0;
   int                   rcv_stall_pct = 0;
   int                   hold_left = 0;
   int                   quiet_cycles = 0;
   logic [TIME_W-1:0]    now_t = '0;
   finish_time_board     board;

   efpm_stream_if #(.payload_type(req_payload_type)) req_if ();
   efpm_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   earliest_finish_pe_mapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // result side: check each beat, then pick ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) board.check_placement(rsp_if.payload);
      if (hold_start) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic req_payload_type make_beat(cmd_type c, logic [TIME_W-1:0] t,
                                                 logic [JOB_W-1:0] jobs, logic [MASK_W-1:0] m,
                                                 logic [EXEC_W-1:0] e0, e1, e2, e3);
      req_payload_type b;
      b.cmd             = c;
      b.time_value      = t;
      b.job_count       = jobs;
      b.allowed_mask    = m;
      b.exec_time_type0 = e0;
      b.exec_time_type1 = e1;
      b.exec_time_type2 = e2;
      b.exec_time_type3 = e3;
      return b;
   endfunction

   function automatic logic [EXEC_W-1:0] pick_exec();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 80) return $urandom_range(0, 1000);
      if (sel < 95) return $urandom;
      if (sel < 97) return '0;
      return '1;
   endfunction

   function automatic req_payload_type random_beat();
      req_payload_type   b;
      int                sel;
      logic [EXEC_W-1:0] same;
      now_t = now_t + $urandom_range(0, 100);
      b = make_beat(CMD_SCHEDULE, now_t, 16'($urandom), 8'($urandom),
                    pick_exec(), pick_exec(), pick_exec(), pick_exec());
      if ($urandom_range(0, 99) < 8) begin
         b.cmd = CMD_INIT;
         sel = $urandom_range(0, 9);
         if (sel == 0)     b.job_count = '0;
         else if (sel == 1) b.job_count = '1;
         else if (sel < 5)  b.job_count = 16'($urandom);
         else               b.job_count = 16'($urandom_range(0, 20));
         return b;
      end
      // times near the ready times make ties and zero waits likely
      sel = $urandom_range(0, 99);
      if (sel < 60)      b.time_value = now_t + $urandom_range(0, 300);
      else if (sel < 85) b.time_value = board.ready_time[$urandom_range(0, NUM_PE_DEF - 1)];
      else               b.time_value = (now_t > 300) ? now_t - $urandom_range(0, 300) : '0;
      sel = $urandom_range(0, 9);
      if (sel == 0)      b.allowed_mask = '0;
      else if (sel == 1) b.allowed_mask = '1;
      else if (sel == 2) b.allowed_mask = 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 99) < 15) begin
         same = pick_exec();
         b.exec_time_type0 = same;
         b.exec_time_type1 = same;
         b.exec_time_type2 = same;
         b.exec_time_type3 = same;
      end
      return b;
   endfunction

   task automatic send_beat(req_payload_type beat);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= beat;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.take_request(beat);
   endtask

   // both registers in back-to-back cycles, enable held high across them
   task automatic program_regs(logic [MAP_W-1:0] map, logic [CSR_W-1:0] cost);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PE_TYPE_MAP;
      csr_wr_data <= map;
      @(posedge clock);
      board.write_reg(CSR_PE_TYPE_MAP, map);
      csr_index   <= CSR_MAPPING_COST;
      csr_wr_data <= cost;
      @(posedge clock);
      board.write_reg(CSR_MAPPING_COST, cost);
      csr_wr_en <= 1'b0;
   endtask

   // an init beat leaves nothing to wait for, so also wait out DRAIN_CYCLES after the last result
   task automatic settle();
      req_if.valid <= 1'b0;
      while (board.placements_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(int idx, int count, int snd, int rcv,
                            logic [MAP_W-1:0] map, logic [CSR_W-1:0] cost, bit pressure);
      program_regs(map, cost);
      snd_idle_pct  = snd;
      rcv_stall_pct = rcv;
      now_t = {3'(idx), 13'($urandom_range(0, 8191)), 32'($urandom)};
      if (pressure) begin
         hold_start <= 1'b1;
         fork
            begin
               @(posedge clock);
               hold_start <= 1'b0;
            end
         join_none
      end
      send_beat(make_beat(CMD_INIT, now_t, 16'($urandom_range(0, 20)), '0, '0, '0, '0, '0));
      repeat (count) send_beat(random_beat());
      settle();
   endtask

   initial begin
      board          = new();
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // element p has type p mod 4
      program_regs(16'hE4E4, MAP_COST_RST);
      send_beat(make_beat(CMD_SCHEDULE, '0, '0, 8'h00, 5, 5, 5, 5));
      send_beat(make_beat(CMD_SCHEDULE, '0, '0, 8'hFF, 5, 5, 5, 5));
      send_beat(make_beat(CMD_SCHEDULE, '0, '0, 8'hFF, 5, 5, 5, 5));
      send_beat(make_beat(CMD_INIT, 48'd1000, '0, '0, '0, '0, '0, '0));
      send_beat(make_beat(CMD_SCHEDULE, '0, '0, 8'h04, 0, 0, 50, 0));
      // equal end times, element 2 waits less than element 1
      send_beat(make_beat(CMD_SCHEDULE, 48'd1100, '0, 8'h06, 10, 10, 10, 10));
      send_beat(make_beat(CMD_SCHEDULE, 48'd1000, '0, 8'hFF, 40, 30, 20, 10));
      send_beat(make_beat(CMD_SCHEDULE, T_MAX, '1, 8'h00, '1, '1, '1, '1));
      send_beat(make_beat(CMD_SCHEDULE, T_MAX, '0, 8'h01, '1, 0, 0, 0));
      send_beat(make_beat(CMD_SCHEDULE, '0, '0, 8'h01, 0, 0, 0, 0));
      send_beat(make_beat(CMD_INIT, 48'd2000, '1, '0, '0, '0, '0, '0));
      send_beat(make_beat(CMD_SCHEDULE, 48'd2000, '0, 8'h11, 7, 7, 7, 7));
      send_beat(make_beat(CMD_SCHEDULE, '0, '0, 8'hFF, '1, '1, '1, '1));
      send_beat(make_beat(CMD_SCHEDULE, 48'd3000, '0, 8'h80, 9, 9, 9, 0));
      settle();

      run_phase(0, PHASE_BEATS, 0, 0, 16'hE4E4, MAP_COST_RST, 1'b0);
      run_phase(1, PHASE_BEATS, 87, 0, 16'h0000, 16'h0000, 1'b0);
      run_phase(2, PHASE_BEATS, 0, 87, 16'hFFFF, 16'hFFFF, 1'b0);
      run_phase(3, PHASE_BEATS, 12, 12, 16'($urandom), 16'($urandom), 1'b0);
      run_phase(4, PHASE_BEATS, 0, 0, 16'h1B1B, 16'h0001, 1'b1);
      run_phase(5, PHASE_BEATS, 12, 12, 16'($urandom), 16'($urandom), 1'b0);

      // saturation at the top of the time range, left for last since it leaves the ready times near the top
      program_regs(16'($urandom), 16'hFFFF);
      snd_idle_pct  = 0;
      rcv_stall_pct = 0;
      send_beat(make_beat(CMD_INIT, T_MAX - 5000, '1, '0, '0, '0, '0, '0));
      repeat (40)
         send_beat(make_beat(CMD_SCHEDULE, T_MAX - $urandom_range(0, 10000), '0, 8'($urandom),
                             pick_exec(), pick_exec(), pick_exec(), pick_exec()));
      send_beat(make_beat(CMD_INIT, T_MAX, '1, '0, '0, '0, '0, '0));
      send_beat(make_beat(CMD_SCHEDULE, '0, '0, 8'hFF, 1, 1, 1, 1));
      send_beat(make_beat(CMD_SCHEDULE, '0, '0, 8'hF0, '1, '1, '1, '1));
      settle();

      board.drain_check();
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
